@@ hdl/bpc_pkg.sv @@
// Package with the types, constants and register codes of the button press classifier.
package bpc_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int FIELD_W     = 8;
  localparam int LANES       = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0]  LONG_PRESS_RESET = TIME_W'(1000);
  localparam logic [FIELD_W-1:0] ACTIVE_LOW_RESET = '1;
  localparam logic [FIELD_W-1:0] IN_USE_RESET     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS_MS   = 2'd0,
    REG_ACTIVE_LOW_MASK = 2'd1,
    REG_IN_USE_MASK     = 2'd2,
    REG_GLOBAL_ENABLE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [FIELD_W-1:0] raw_levels;
    logic [TIME_W-1:0]  now_ms;
  } poll_t;

  typedef struct packed {
    logic [FIELD_W-1:0] short_events;
    logic [FIELD_W-1:0] long_events;
    logic [FIELD_W-1:0] pressed_now;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0]  long_press_ms;
    logic [FIELD_W-1:0] active_low_mask;
    logic [FIELD_W-1:0] in_use_mask;
    logic               global_enable;
  } cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic pressed;
  } lane_out_t;

endpackage

@@ hdl/bpc_cfg.sv @@
// Configuration registers and the lane clear mask raised when a button is registered.
module bpc_cfg
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [LANES-1:0]      lane_clear
);

  reg_idx_t           idx;
  logic [FIELD_W-1:0] rising;

  assign idx    = reg_idx_t'(cfg_index);
  assign rising = cfg_data[FIELD_W-1:0] & ~cfg.in_use_mask;

  always_comb begin
    lane_clear = '0;
    if (cfg_write && idx == REG_IN_USE_MASK) begin
      lane_clear = rising[LANES-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms   <= LONG_PRESS_RESET;
      cfg.active_low_mask <= ACTIVE_LOW_RESET;
      cfg.in_use_mask     <= IN_USE_RESET;
      cfg.global_enable   <= 1'b1;
    end else if (cfg_write) begin
      case (idx)
        REG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data[TIME_W-1:0];
        REG_ACTIVE_LOW_MASK: cfg.active_low_mask <= cfg_data[FIELD_W-1:0];
        REG_IN_USE_MASK:     cfg.in_use_mask     <= cfg_data[FIELD_W-1:0];
        REG_GLOBAL_ENABLE:   cfg.global_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/bpc_lane.sv @@
// State and edge, short press and long press logic of one button.
module bpc_lane
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              step,
  input  logic              raw,
  input  logic              active_low,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [TIME_W-1:0] long_press_ms,
  output lane_out_t         res
);

  logic              held;
  logic [TIME_W-1:0] stamp;
  logic              long_fired;
  logic              shown;

  logic              level;
  logic              press_edge;
  logic              release_edge;
  logic [TIME_W-1:0] stamp_next;
  logic              fired_mid;
  logic [TIME_W-1:0] hold_time;
  logic              long_hit;

  assign level        = raw ^ active_low;
  assign press_edge   = level && !held;
  assign release_edge = !level && held;
  assign stamp_next   = press_edge ? now_ms : stamp;
  assign fired_mid    = press_edge ? 1'b0 : long_fired;
  assign hold_time    = now_ms - stamp_next;
  assign long_hit     = level && !fired_mid && (hold_time >= long_press_ms);

  always_comb begin
    res.short_ev = step && release_edge && !long_fired;
    res.long_ev  = step && long_hit;
    res.pressed  = step ? level : shown;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held       <= 1'b0;
      stamp      <= '0;
      long_fired <= 1'b0;
      shown      <= 1'b0;
    end else if (step) begin
      held       <= level;
      stamp      <= stamp_next;
      long_fired <= fired_mid || long_hit;
      shown      <= level;
    end
  end

endmodule

@@ hdl/button_press_classifier_unit.sv @@
// Top level of the button press classifier: poll register, button lanes and result register.
//
// A poll item carries the raw pin levels of eight buttons and a millisecond time.
// It enters on the poll channel (poll_valid, poll_stall) and is held in an input
// register. Once the output register can take it, every button lane that is in use
// compares its logical level with its held level, if global enable is set, and the
// result item is written to the output register, which drives the result channel
// (result_valid, result_stall). Exactly one result item follows each poll item.
// One poll item is taken in every cycle while poll_stall is low.
// While the receiver stalls, the result stays unchanged and one more poll item
// can wait in the input register; only then does poll_stall rise.
// Configuration is written through cfg_write, cfg_index and cfg_data, which the
// user must do only while no item is in flight; the block does not enforce this.
// Registering a button clears its lane state. Synchronous reset empties both
// registers, clears all lane state and loads the configuration reset values.
module button_press_classifier_unit
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  poll_valid,
  output logic                  poll_stall,
  input  poll_t                 poll,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg;
  logic [LANES-1:0]   lane_clear;
  poll_t              poll_q;
  logic               poll_q_valid;
  logic               advance;
  lane_out_t          lane_res [LANES];
  result_t            result_next;

  assign advance    = poll_q_valid && (!result_valid || !result_stall);
  assign poll_stall = poll_q_valid && result_valid && result_stall;

  bpc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .lane_clear (lane_clear)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bpc_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .clear         (lane_clear[i]),
      .step          (advance && cfg.global_enable && cfg.in_use_mask[i]),
      .raw           (poll_q.raw_levels[i]),
      .active_low    (cfg.active_low_mask[i]),
      .now_ms        (poll_q.now_ms),
      .long_press_ms (cfg.long_press_ms),
      .res           (lane_res[i])
    );
  end

  always_comb begin
    result_next = '0;
    for (int i = 0; i < LANES; i++) begin
      result_next.short_events[i] = lane_res[i].short_ev;
      result_next.long_events[i]  = lane_res[i].long_ev;
      result_next.pressed_now[i]  = lane_res[i].pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (poll_valid && !poll_stall) begin
      poll_q_valid <= 1'b1;
    end else if (advance) begin
      poll_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      poll_q <= poll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

@@ hdl/bpc_checker.sv @@
// Port checker of the button press classifier and its bind to the top level.
module bpc_checker
  import bpc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    poll_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result item changed or was dropped.");

  a_short_long_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.short_events & result.long_events) == '0)
    else $error("A button reported a short and a long press in one item.");

  a_event_level: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.short_events & result.pressed_now) == '0 &&
                     (result.long_events & ~result.pressed_now) == '0)
    else $error("Press event disagrees with the pressed state of the button.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !poll_stall)
    else $error("Item registers not empty after reset.");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_stall   (poll_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ dv/button_press_classifier_unit_tb.sv @@
// Testbench for the button press classifier: directed table, random polls and lane predictor.
`timescale 1ns / 100ps

module button_press_classifier_unit_tb;
  import bpc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASES          = 9;
  localparam int PHASE_POLLS     = 215;
  localparam int ROWS            = 28;

  typedef struct packed {
    logic                  is_write;
    reg_idx_t              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    poll_t                 item;
    logic                  fixed;
    result_t               want;
  } step_row_t;

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  poll_valid   = 1'b0;
  logic                  poll_stall;
  poll_t                 poll         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  cfg_t                  settings;
  logic [LANES-1:0]      held_lanes;
  logic [LANES-1:0]      fired_lanes;
  logic [LANES-1:0]      shown_lanes;
  logic [TIME_W-1:0]     press_time [LANES];
  result_t               pending_results [$];
  step_row_t             directed_rows [ROWS];
  int                    mismatch_count = 0;
  bit                    idle_on        = 1'b1;
  bit                    hold_off_req   = 1'b0;

  button_press_classifier_unit uut (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void apply_register_write(reg_idx_t sel, logic [CFG_DATA_W-1:0] val);
    logic [FIELD_W-1:0] newly_used;
    newly_used = val[FIELD_W-1:0] & ~settings.in_use_mask;
    case (sel)
      REG_LONG_PRESS_MS: settings.long_press_ms = val[TIME_W-1:0];
      REG_ACTIVE_LOW_MASK: settings.active_low_mask = val[FIELD_W-1:0];
      REG_IN_USE_MASK: begin
        for (int i = 0; i < LANES; i++) begin
          if (newly_used[i]) begin
            held_lanes[i]  = 1'b0;
            fired_lanes[i] = 1'b0;
            shown_lanes[i] = 1'b0;
            press_time[i]  = '0;
          end
        end
        settings.in_use_mask = val[FIELD_W-1:0];
      end
      REG_GLOBAL_ENABLE: settings.global_enable = val[0];
      default: begin
      end
    endcase
  endfunction

  function automatic result_t classify_poll(poll_t p);
    result_t           r;
    logic              lvl;
    logic [TIME_W-1:0] held_for;
    r = '0;
    if (settings.global_enable) begin
      for (int i = 0; i < LANES; i++) begin
        if (settings.in_use_mask[i]) begin
          lvl = p.raw_levels[i] ^ settings.active_low_mask[i];
          if (lvl != held_lanes[i]) begin
            held_lanes[i] = lvl;
            if (lvl) begin
              press_time[i]  = p.now_ms;
              fired_lanes[i] = 1'b0;
            end else if (!fired_lanes[i]) begin
              r.short_events[i] = 1'b1;
            end
          end
          held_for = p.now_ms - press_time[i];
          if (held_lanes[i] && !fired_lanes[i] && held_for >= settings.long_press_ms) begin
            r.long_events[i] = 1'b1;
            fired_lanes[i]   = 1'b1;
          end
          shown_lanes[i] = lvl;
        end
      end
    end
    r.pressed_now[LANES-1:0] = shown_lanes;
    return r;
  endfunction

  task automatic send_poll(poll_t p, logic fixed, result_t want);
    result_t predicted;
    while (idle_on && $urandom_range(0, 99) < 12) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll       <= p;
    poll_valid <= 1'b1;
    do @(posedge clk); while (poll_stall);
    predicted = classify_poll(p);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic wait_drained();
    poll_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t sel, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    apply_register_write(sel, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    poll_t                 item;
    logic [FIELD_W-1:0]    levels;
    logic [FIELD_W-1:0]    flips;
    logic [TIME_W-1:0]     clock_ms;
    logic [CFG_DATA_W-1:0] threshold;
    settings    = '{LONG_PRESS_RESET, ACTIVE_LOW_RESET, IN_USE_RESET, 1'b1};
    held_lanes  = '0;
    fired_lanes = '0;
    shown_lanes = '0;
    foreach (press_time[i]) press_time[i] = '0;
    directed_rows = '{
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hFF, 32'd0}, 1'b1, {8'h00, 8'h00, 8'h00}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'hFFFF_FFFF}, 1'b1, {8'h00, 8'h00, 8'h00}},
      '{1'b1, REG_IN_USE_MASK, 32'hFF, 40'h0, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hFF, 32'd100}, 1'b1, {8'h00, 8'h00, 8'h00}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'd100}, 1'b1, {8'h00, 8'h00, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'd1099}, 1'b1, {8'h00, 8'h00, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'd1100}, 1'b1, {8'h00, 8'hFF, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hFF, 32'd1200}, 1'b1, {8'h00, 8'h00, 8'h00}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hFE, 32'd2000}, 1'b1, {8'h00, 8'h00, 8'h01}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hFF, 32'd2001}, 1'b1, {8'h01, 8'h00, 8'h00}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'hFFFF_FF00}, 1'b1, {8'h00, 8'h00, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'h0000_02E7}, 1'b1, {8'h00, 8'h00, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'h0000_02E8}, 1'b1, {8'h00, 8'hFF, 8'hFF}},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hF0, 32'h0000_02E9}, 1'b1, {8'h00, 8'h00, 8'h0F}},
      '{1'b1, REG_LONG_PRESS_MS, 32'h0, 40'h0, 1'b0, 24'h0},
      '{1'b1, REG_ACTIVE_LOW_MASK, 32'h0, 40'h0, 1'b0, 24'h0},
      '{1'b1, REG_IN_USE_MASK, 32'h0F, 40'h0, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h01, 32'd5000}, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hAA, 32'd5001}, 1'b0, 24'h0},
      '{1'b1, REG_IN_USE_MASK, 32'hFF, 40'h0, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'hF0, 32'd5002}, 1'b0, 24'h0},
      '{1'b1, REG_GLOBAL_ENABLE, 32'h0, 40'h0, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h0F, 32'd5003}, 1'b0, 24'h0},
      '{1'b1, REG_GLOBAL_ENABLE, 32'h1, 40'h0, 1'b0, 24'h0},
      '{1'b1, REG_LONG_PRESS_MS, 32'hFFFF_FFFF, 40'h0, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h01, 32'h0000_1000}, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h01, 32'h0000_0FFF}, 1'b0, 24'h0},
      '{1'b0, REG_LONG_PRESS_MS, 32'h0, {8'h00, 32'h0000_1000}, 1'b0, 24'h0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_write) begin
        write_register(directed_rows[r].reg_sel, directed_rows[r].reg_val);
      end else begin
        send_poll(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].want);
      end
    end

    // Each phase holds one setting; time mostly creeps forward and buttons toggle now and then.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph != 1);
      case ($urandom_range(0, 5))
        0: threshold = '0;
        1: threshold = '1;
        2: threshold = $urandom;
        default: threshold = $urandom_range(1, 150);
      endcase
      write_register(REG_LONG_PRESS_MS, threshold);
      write_register(REG_ACTIVE_LOW_MASK, $urandom_range(0, 255));
      write_register(REG_IN_USE_MASK, $urandom_range(0, 1) ? 32'hFF : $urandom_range(0, 255));
      write_register(REG_GLOBAL_ENABLE, CFG_DATA_W'(ph != 6));
      if (ph == 3) hold_off_req = 1'b1;
      clock_ms = (ph == 2) ? 32'hFFFF_FF80 : $urandom;
      levels   = FIELD_W'($urandom);
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if ($urandom_range(0, 99) < 5) begin
          levels   = FIELD_W'($urandom);
          clock_ms = $urandom;
        end else begin
          for (int b = 0; b < FIELD_W; b++) flips[b] = ($urandom_range(0, 7) == 0);
          levels   = levels ^ flips;
          clock_ms = clock_ms + $urandom_range(0, 25);
        end
        item = {levels, clock_ms};
        send_poll(item, 1'b0, '0);
        if (ph == 5 && n == PHASE_POLLS / 2) wait_drained();
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= idle_on && ($urandom_range(0, 99) < 12);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none pending, got %h", $time, result);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.short_events !== want.short_events) begin
          $display("%0t: short_events expected %h, got %h", $time,
                   want.short_events, result.short_events);
          mismatch_count++;
        end
        if (result.long_events !== want.long_events) begin
          $display("%0t: long_events expected %h, got %h", $time,
                   want.long_events, result.long_events);
          mismatch_count++;
        end
        if (result.pressed_now !== want.pressed_now) begin
          $display("%0t: pressed_now expected %h, got %h", $time,
                   want.pressed_now, result.pressed_now);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((poll_valid && !poll_stall) || (result_valid && !result_stall) || cfg_write) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
hdl/bpc_pkg.sv
hdl/bpc_cfg.sv
hdl/bpc_lane.sv
hdl/button_press_classifier_unit.sv
hdl/bpc_checker.sv
dv/button_press_classifier_unit_tb.sv
